FILE: design/skf_pkg.sv
// Shared constants and register codes for the scalar Kalman filter unit.
package skf_pkg;

  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int CFG_INDEX_BITS  = 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } cfg_reg_t;

endpackage

FILE: design/skf_divider.sv
// Restoring divider that forms the filter gain one quotient bit per cycle.
module skf_divider import skf_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [FRAC_BITS+1:0] pred,
  input  logic [FRAC_BITS+1:0] noise,
  output logic                 done,
  output logic [FRAC_BITS-1:0] gain
);

  localparam int F     = FRAC_BITS;
  localparam int CNT_W = $clog2(F + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [F+2:0]     denom;
  logic [F+3:0]     rem;
  logic [F:0]       quo;

  logic         ge;
  logic [F+3:0] rem_sub;
  logic [F+3:0] rem_keep;
  logic [F+3:0] rem_next;
  logic [F:0]   quo_next;

  // One trial subtraction per cycle; the remainder is shifted for the next bit.
  assign ge       = rem >= {1'b0, denom};
  assign rem_sub  = rem - {1'b0, denom};
  assign rem_keep = ge ? rem_sub : rem;
  assign rem_next = {rem_keep[F+2:0], 1'b0};
  assign quo_next = {quo[F-1:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        denom <= {1'b0, pred} + {1'b0, noise};
        rem   <= {2'b00, pred};
        cnt   <= CNT_W'(F);
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          // A zero divisor gives no gain; a quotient of exactly one saturates.
          if (denom == '0) begin
            gain <= '0;
          end else if (quo_next[F]) begin
            gain <= '1;
          end else begin
            gain <= quo_next[F-1:0];
          end
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/scalar_kalman_filter_unit.sv
// Top level of the scalar Kalman filter unit: control, serial multipliers and state.
//
// The unit filters a stream of signed sensor samples. A sample beat is taken on
// the input channel when in_valid is high and in_stall is low; in_stall stays
// high while a sample is being worked on, so one sample is in flight at a time.
// Each sample produces exactly one beat on the output channel carrying the new
// estimate, rounded half up to an integer.
//
// From acceptance to the output register, one sample runs the predict step and the
// divider load, then FRAC_BITS + 1 divider steps for the gain, one quotient bit
// per cycle, then FRAC_BITS steps of the two shift-add multipliers side by side,
// then the update and output steps. The next sample can be taken in the cycle
// after the result is registered; no new sample is taken before the last is through.
//
// The finished estimate sits in an output register. If the receiver stalls,
// that beat holds, and the next sample is still accepted and worked on; it only
// waits at its last step until the output register is free.
//
// Reset (rst, synchronous, active high) clears the estimate to zero, sets the covariance to
// 1.0 and loads the default noise registers. The noise registers are written through
// cfg_write/cfg_index/cfg_data by the user only while the unit is idle; the block does not enforce it.
module scalar_kalman_filter_unit import skf_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] measurement,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] estimate,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [FRAC_BITS+1:0]          cfg_data
);

  localparam int S      = SAMPLE_BITS;
  localparam int F      = FRAC_BITS;
  localparam int COV_W  = F + 2;
  localparam int EST_W  = S + F;
  localparam int DIFF_W = EST_W + 1;
  localparam int ACC_W  = EST_W + 2;
  localparam int MCNT_W = $clog2(F);

  // Default noise values: 0.009 and 0.10 in Q2.F, rounded to nearest.
  localparam longint ONE_L   = longint'(1) << F;
  localparam longint Q_RST_L = (ONE_L * 9 + 500) / 1000;
  localparam longint R_RST_L = (ONE_L + 5) / 10;

  localparam logic [COV_W-1:0] COV_ONE = {2'b01, {F{1'b0}}};
  localparam logic [COV_W-1:0] Q_RESET = COV_W'(Q_RST_L);
  localparam logic [COV_W-1:0] R_RESET = COV_W'(R_RST_L);
  localparam logic [EST_W-1:0] HALF    = EST_W'(ONE_L >> 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRED,
    S_DIV,
    S_MUL,
    S_UPD,
    S_FIN
  } state_t;

  state_t state;

  // Configuration and filter state.
  logic [COV_W-1:0]        process_noise;
  logic [COV_W-1:0]        measurement_noise;
  logic signed [EST_W-1:0] est;
  logic [COV_W-1:0]        cov;

  // Per-sample working registers.
  logic signed [S-1:0]      meas_r;
  logic [COV_W-1:0]         pred;
  logic signed [DIFF_W-1:0] diff;
  logic [F-1:0]             gain_sh;
  logic [F-1:0]             om_sh;
  logic                     om_top;
  logic signed [ACC_W-1:0]  acc_e;
  logic [COV_W-1:0]         acc_c;
  logic [MCNT_W-1:0]        mcnt;
  logic                     div_start;

  logic         div_done;
  logic [F-1:0] div_gain;

  logic [COV_W:0]          pred_sum;
  logic [F:0]              om_full;
  logic signed [ACC_W-1:0] acc_e_sum;
  logic signed [ACC_W-1:0] acc_e_next;
  logic [COV_W:0]          acc_c_sum;
  logic [EST_W-1:0]        est_rnd;

  skf_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .pred  (pred),
    .noise (measurement_noise),
    .done  (div_done),
    .gain  (div_gain)
  );

  assign in_stall = (state != S_IDLE);

  assign pred_sum = {1'b0, cov} + {1'b0, process_noise};
  assign om_full  = {1'b1, {F{1'b0}}} - {1'b0, div_gain};

  // Estimate product: add the difference when the gain bit is set, then an
  // arithmetic shift right, so after F steps the accumulator holds the floor.
  assign acc_e_sum  = acc_e + (gain_sh[0] ? {diff[DIFF_W-1], diff} : ACC_W'(0));
  assign acc_e_next = {acc_e_sum[ACC_W-1], acc_e_sum[ACC_W-1:1]};

  // Covariance product: (1 - gain) * pred, same shift-add scheme, unsigned.
  assign acc_c_sum = {1'b0, acc_c} + {1'b0, (om_sh[0] ? pred : COV_W'(0))};

  assign est_rnd = est + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      div_start         <= 1'b0;
      est               <= '0;
      cov               <= COV_ONE;
      process_noise     <= Q_RESET;
      measurement_noise <= R_RESET;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PROCESS_NOISE:     process_noise     <= cfg_data;
          REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            meas_r <= measurement;
            state  <= S_PRED;
          end
        end
        S_PRED: begin
          // Predicted covariance saturates at the top of Q2.F.
          pred      <= pred_sum[COV_W] ? '1 : pred_sum[COV_W-1:0];
          diff      <= {meas_r[S-1], meas_r, {F{1'b0}}} - {est[EST_W-1], est};
          div_start <= 1'b1;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            gain_sh <= div_gain;
            om_sh   <= om_full[F-1:0];
            om_top  <= om_full[F];
            acc_e   <= '0;
            acc_c   <= '0;
            mcnt    <= MCNT_W'(F - 1);
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          acc_e   <= acc_e_next;
          acc_c   <= acc_c_sum[COV_W:1];
          gain_sh <= gain_sh >> 1;
          om_sh   <= om_sh >> 1;
          if (mcnt == '0) begin
            state <= S_UPD;
          end else begin
            mcnt <= mcnt - 1'b1;
          end
        end
        S_UPD: begin
          // The new estimate lies between the old one and the sample.
          est   <= est + acc_e[EST_W-1:0];
          cov   <= om_top ? pred : acc_c;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            estimate  <= est_rnd[EST_W-1:F];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The divider only reports a gain while the controller is waiting for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("gain delivered outside the divide phase");

  a_div_done_to_mul: assert property (@(posedge clk) disable iff (rst)
    div_done |=> state == S_MUL)
    else $error("controller did not start the multiply after the gain");

  // (1 - gain) * pred can never grow past pred.
  a_cov_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> acc_c <= pred)
    else $error("covariance accumulator exceeds the predicted covariance");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("output beat raised outside the final step");

endmodule

FILE: tb/scalar_kalman_filter_unit_tb.sv
// Self-checking testbench for the scalar Kalman filter unit, checked against an in-bench predictor.
module scalar_kalman_filter_unit_tb;
  import skf_pkg::*;

  localparam int SB = DEF_SAMPLE_BITS;
  localparam int FB = DEF_FRAC_BITS;
  localparam int CB = FB + 2;

  // Fixed-point constants of the filter, kept at 64 bits for the predictor.
  localparam longint unsigned ONE_Q     = 64'd1 << FB;
  localparam longint          ONE_S     = 64'sd1 << FB;
  localparam longint          HALF_S    = 64'sd1 << (FB - 1);
  localparam longint unsigned COV_MAX   = (64'd1 << CB) - 64'd1;
  localparam logic [CB-1:0]   NOISE_Q_RESET = 18'd590;
  localparam logic [CB-1:0]   NOISE_R_RESET = 18'd6554;

  // LATENCY stands for the time from a sample's acceptance to its result; the tail wait
  // derives from it.
  localparam int LATENCY     = 2 * FB + 6;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_PRINTED = 100;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SB-1:0] measurement = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SB-1:0] estimate;
  logic                 cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_PROCESS_NOISE;
  logic [CB-1:0]        cfg_data = '0;

  scalar_kalman_filter_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .measurement (measurement),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .estimate    (estimate),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor state: the running estimate in signed Q16.16, the carried covariance
  // in unsigned Q2.16 and a copy of the two noise registers as the block holds them.
  longint          filt_est  = 0;
  longint unsigned filt_cov  = ONE_Q;
  longint unsigned noise_q   = NOISE_Q_RESET;
  longint unsigned noise_r   = NOISE_R_RESET;

  // Estimates still owed by the block, oldest first.
  logic signed [SB-1:0] estimates_due[$];

  int errors = 0;
  int cycles = 0;

  // Idling controls, changed per phase: percent of cycles the sender holds back a
  // beat and percent of cycles the receiver stalls the output channel.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // A directed row is either a register write or one sample beat. A sample row may
  // carry a hand-typed estimate, which then replaces the predicted one.
  typedef struct packed {
    logic                      is_cfg;
    logic [CFG_INDEX_BITS-1:0] target;
    logic [CB-1:0]             value;
    logic signed [SB-1:0]      meas;
    logic                      typed;
    logic signed [SB-1:0]      typed_est;
  } plan_row_t;

  plan_row_t directed_plan[$];

  function automatic bit roll(input int pct);
    return (pct != 0) && ($urandom_range(99) < pct);
  endfunction

  // Advances the predictor by one sample and returns the rounded estimate. The
  // gain product is taken as one floored division; that equals the split form
  // since the difference and the gain both fit well inside 64 bits.
  function automatic logic signed [SB-1:0] kalman_step(input logic signed [SB-1:0] m);
    longint unsigned pred;
    longint unsigned denom;
    longint unsigned gain;
    longint          diff;
    longint          rounded;
    pred = filt_cov + noise_q;
    if (pred > COV_MAX) begin
      pred = COV_MAX;
    end
    denom = pred + noise_r;
    if (denom == 0) begin
      gain = 0;
    end else begin
      gain = (pred << FB) / denom;
      if (gain > ONE_Q - 1) begin
        gain = ONE_Q - 1;
      end
    end
    diff = longint'(m) * ONE_S - filt_est;
    filt_est = filt_est + ((longint'(gain) * diff) >>> FB);
    filt_cov = ((ONE_Q - gain) * pred) >> FB;
    rounded = (filt_est + HALF_S) >>> FB;
    return rounded[SB-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("ERROR at cycle %0d: %s", cycles, msg);
    end
  endtask

  // Lowers valid and waits until every owed estimate has come back. It always
  // lets at least one edge pass, so valid never gets two assignments in one step.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (estimates_due.size() != 0);
  endtask

  // Register writes happen only with the block idle. Every sample yields exactly
  // one estimate, so an empty queue of owed estimates means the block is idle.
  task automatic write_noise(input logic [CFG_INDEX_BITS-1:0] sel, input logic [CB-1:0] value);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (sel == REG_PROCESS_NOISE) begin
      noise_q = value;
    end else begin
      noise_r = value;
    end
  endtask

  // Presents one sample beat, holding it steady until it is taken. Valid is left
  // high afterwards; the next call either replaces the payload in the same step or
  // lowers valid for an idle gap, and every other caller lowers it first.
  task automatic send_sample(input logic signed [SB-1:0] m, input logic typed,
                             input logic signed [SB-1:0] typed_est);
    logic signed [SB-1:0] predicted;
    if (roll(send_idle_pct)) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (roll(send_idle_pct));
    end
    in_valid    <= 1'b1;
    measurement <= m;
    do @(posedge clk); while (in_stall);
    predicted = kalman_step(m);
    estimates_due.push_back(typed ? typed_est : predicted);
  endtask

  function automatic void plan_sample(input logic signed [SB-1:0] m, input logic typed,
                                      input logic signed [SB-1:0] typed_est);
    plan_row_t row;
    row = '0;
    row.meas = m;
    row.typed = typed;
    row.typed_est = typed_est;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_config(input logic [CFG_INDEX_BITS-1:0] sel,
                                      input logic [CB-1:0] value);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.target = sel;
    row.value = value;
    directed_plan.push_back(row);
  endfunction

  // Picks a noise setting: extremes, tiny values, values below 4096 or anything at all.
  function automatic logic [CB-1:0] pick_noise();
    case ($urandom_range(5))
      0: return '0;
      1: return COV_MAX[CB-1:0];
      2: return CB'($urandom_range(0, 1));
      3: return CB'($urandom_range(0, 4095));
      default: return CB'($urandom_range(0, int'(COV_MAX)));
    endcase
  endfunction

  // Output side: the receiver stalls at random per the current phase, and every
  // beat it takes is compared with the oldest owed estimate.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (estimates_due.size() == 0) begin
        report_mismatch($sformatf("estimate beat %0d with nothing owed", estimate));
      end else begin
        if (estimate !== estimates_due[0]) begin
          report_mismatch($sformatf("estimate got %0d, wanted %0d",
                                    estimate, estimates_due[0]));
        end
        void'(estimates_due.pop_front());
      end
    end
    out_stall <= roll(recv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("scalar_kalman_filter_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    plan_row_t row;
    int level;
    int v;
    logic signed [SB-1:0] m;

    // Directed part. From reset the estimate is zero, so zero samples must give zero.
    plan_sample(16'sd0, 1'b1, 16'sd0);
    plan_sample(16'sd0, 1'b1, 16'sd0);
    plan_sample(16'sd32767, 1'b0, '0);
    plan_sample(-16'sd32768, 1'b0, '0);
    plan_sample(16'sd1, 1'b0, '0);
    plan_sample(-16'sd1, 1'b0, '0);
    plan_sample(16'sh5555, 1'b0, '0);
    plan_sample(16'shAAAA, 1'b0, '0);
    // Both noise terms at full scale drive the predicted covariance into saturation.
    plan_config(REG_PROCESS_NOISE, COV_MAX[CB-1:0]);
    plan_config(REG_MEASUREMENT_NOISE, COV_MAX[CB-1:0]);
    plan_sample(16'sd32767, 1'b0, '0);
    plan_sample(-16'sd32768, 1'b0, '0);
    plan_sample(16'sd0, 1'b0, '0);
    // With no noise at all the gain first pins just under one; within two samples
    // the covariance reaches zero and the divisor of the gain becomes zero.
    plan_config(REG_PROCESS_NOISE, '0);
    plan_config(REG_MEASUREMENT_NOISE, '0);
    plan_sample(-16'sd32768, 1'b0, '0);
    plan_sample(16'sd32767, 1'b0, '0);
    plan_sample(16'sd32767, 1'b0, '0);
    plan_sample(-16'sd123, 1'b0, '0);
    plan_sample(16'sd0, 1'b0, '0);
    // Saturated prediction against zero measurement noise.
    plan_config(REG_PROCESS_NOISE, COV_MAX[CB-1:0]);
    plan_sample(16'sd1000, 1'b0, '0);
    plan_sample(-16'sd1000, 1'b0, '0);
    // No process noise but full measurement noise: the gain decays toward zero.
    plan_config(REG_PROCESS_NOISE, '0);
    plan_config(REG_MEASUREMENT_NOISE, COV_MAX[CB-1:0]);
    plan_sample(16'sd500, 1'b0, '0);
    plan_sample(-16'sd500, 1'b0, '0);
    plan_config(REG_PROCESS_NOISE, NOISE_Q_RESET);
    plan_config(REG_MEASUREMENT_NOISE, NOISE_R_RESET);
    plan_sample(16'sd200, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.is_cfg) begin
        write_noise(row.target, row.value);
      end else begin
        send_sample(row.meas, row.typed, row.typed_est);
      end
    end

    // Random part: four idling phases, each cut into runs of a hundred beats with
    // fresh noise settings in between. Most samples follow a slowly moving level
    // with small noise, as a real sensor would; the rest are arbitrary or extreme.
    level = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct = 16;
          recv_stall_pct = 16;
        end
      endcase
      for (int run = 0; run < 5; run++) begin
        write_noise(REG_PROCESS_NOISE, pick_noise());
        write_noise(REG_MEASUREMENT_NOISE, pick_noise());
        for (int k = 0; k < 100; k++) begin
          // Now and then the sender waits for the block to empty completely.
          if (k == 50 || $urandom_range(99) == 0) begin
            drain();
          end
          case ($urandom_range(9))
            0, 1, 2: m = SB'($urandom);
            3: begin
              case ($urandom_range(3))
                0: m = 16'sd32767;
                1: m = -16'sd32768;
                2: m = 16'sd0;
                default: m = -16'sd1;
              endcase
            end
            default: begin
              if ($urandom_range(7) == 0) begin
                level = int'($urandom_range(0, 65535)) - 32768;
              end
              v = level + int'($urandom_range(0, 127)) - 64;
              if (v > 32767) begin
                v = 32767;
              end else if (v < -32768) begin
                v = -32768;
              end
              m = v[SB-1:0];
            end
          endcase
          send_sample(m, 1'b0, '0);
        end
      end
    end

    // Wind down: collect every owed estimate, then watch a little longer for
    // stray beats before giving the verdict.
    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("scalar_kalman_filter_unit_tb: PASS");
    end else begin
      $display("scalar_kalman_filter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
